>>> rtl/msrs_pkg.sv
// ----------------------------------------------------------------------------
// Request server package
// Shared types and codes for the multi-slot request server.
// ----------------------------------------------------------------------------
package msrs_pkg;

  typedef enum logic [1:0] {
    OP_ARRIVE = 2'd0,
    OP_TICK   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KIND_ACCEPTED  = 3'd0,
    KIND_DROPPED   = 3'd1,
    KIND_STARTED   = 3'd2,
    KIND_COMPLETED = 3'd3,
    KIND_STATUS    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CFG_SERVICE_TICKS = 2'd0,
    CFG_QUEUE_LIMIT   = 2'd1,
    CFG_SLOT_COUNT    = 2'd2
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_FILL,
    ST_STATUS,
    ST_PRIME,
    ST_EMIT
  } state_e;

  // One buffered result before the step totals are attached.
  typedef struct packed {
    logic [31:0] wait_ticks;
    logic [15:0] tag;
    kind_e       kind;
  } res_t;

endpackage

>>> rtl/msrs_fifo.sv
// ----------------------------------------------------------------------------
// Request queue
// Circular buffer of waiting tags and arrival times with a registered head read.
// ----------------------------------------------------------------------------
module msrs_fifo #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  logic          push_i,
  input  logic [15:0]   push_tag_i,
  input  logic [31:0]   push_time_i,
  input  logic          pop_i,
  output logic [CW-1:0] count_o,
  output logic [15:0]   head_tag_o,
  output logic [31:0]   head_time_o
);

  logic [15:0]   tag_mem  [DEPTH];
  logic [31:0]   time_mem [DEPTH];
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW:0]   tail_sum;
  logic [IW-1:0] tail;
  logic [IW-1:0] head_inc;
  logic [15:0]   rd_tag_q;
  logic [31:0]   rd_time_q;

  always_comb begin
    tail_sum = (IW + 1)'(head_q) + (IW + 1)'(count_q);
    if (tail_sum >= (IW + 1)'(DEPTH)) begin
      tail = IW'(tail_sum - (IW + 1)'(DEPTH));
    end else begin
      tail = IW'(tail_sum);
    end
    if (head_q == IW'(DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head_q + IW'(1);
    end
    head_d  = head_q;
    count_d = count_q;
    if (clear_i) begin
      head_d  = '0;
      count_d = '0;
    end else if (push_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i) begin
      head_d  = head_inc;
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !clear_i) begin
      tag_mem[tail]  <= push_tag_i;
      time_mem[tail] <= push_time_i;
    end
    rd_tag_q  <= tag_mem[head_d];
    rd_time_q <= time_mem[head_d];
  end

  assign count_o     = count_q;
  assign head_tag_o  = rd_tag_q;
  assign head_time_o = rd_time_q;

endmodule

>>> rtl/msrs_rbuf.sv
// ----------------------------------------------------------------------------
// Result buffer
// Holds the results of one step until the step totals are known.
// ----------------------------------------------------------------------------
module msrs_rbuf #(
  parameter int unsigned DEPTH = 17,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  msrs_pkg::res_t  wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output msrs_pkg::res_t  rdata_o
);

  msrs_pkg::res_t mem [DEPTH];
  msrs_pkg::res_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/multi_slot_request_server_core.sv
// ----------------------------------------------------------------------------
// Multi-slot request server
// Bounded request queue in front of a set of timed service slots.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the input is not ready until every result
// of the current item has been loaded into the output register. An arrive or
// clear item gives one result and a tick item gives one to 2 * MAX_SLOTS + 1
// results: a single compare, decrement and subtract unit visits the slots one
// per cycle, first to retire expired requests and then to start queued ones,
// and the results are then read back from the result buffer one per cycle
// while the output is not stalled.
module multi_slot_request_server_core #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned MAX_SLOTS   = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [15:0]  s_axis_tdata_i,   // request_tag
  input  logic [1:0]   s_axis_tuser_i,   // operation
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tag, wait_ticks, busy_slots, queue_depth, completed_total, dropped_total
  output logic [127:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o,   // kind
  output logic         m_axis_tlast_o
);

  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LW  = (CW > 5) ? CW : 5;
  localparam int unsigned SIW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned UW  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned SCW = (UW > 4) ? UW : 4;
  localparam int unsigned RD  = 2 * MAX_SLOTS + 1;
  localparam int unsigned RW  = $clog2(RD);
  localparam int unsigned NW  = $clog2(RD + 1);

  logic [15:0] service_ticks_q;
  logic [4:0]  queue_limit_q;
  logic [3:0]  slot_count_q;

  msrs_pkg::state_e state_q, state_d;
  logic [SIW-1:0]   idx_q, idx_d;
  logic [31:0]      time_q, time_d;
  logic [31:0]      completed_q, completed_d;
  logic [31:0]      dropped_q, dropped_d;
  logic [UW-1:0]    busy_cnt_q, busy_cnt_d;
  logic [MAX_SLOTS-1:0] slot_busy_q, slot_busy_d;
  logic [15:0]      slot_tag_q [MAX_SLOTS];
  logic [15:0]      slot_tag_d [MAX_SLOTS];
  logic [15:0]      slot_rem_q [MAX_SLOTS];
  logic [15:0]      slot_rem_d [MAX_SLOTS];
  logic [NW-1:0]    wr_q, wr_d;
  logic [RW-1:0]    rd_q, rd_d;

  logic             out_valid_q, out_valid_d;
  msrs_pkg::res_t   out_res_q, out_res_d;
  logic [3:0]       out_busy_q, out_busy_d;
  logic [4:0]       out_depth_q, out_depth_d;
  logic [31:0]      out_comp_q, out_comp_d;
  logic [31:0]      out_drop_q, out_drop_d;
  logic             out_last_q, out_last_d;

  logic             rb_we;
  msrs_pkg::res_t   rb_wdata;
  msrs_pkg::res_t   rb_rdata;

  logic             q_clear, q_push, q_pop;
  logic [CW-1:0]    q_count;
  logic [15:0]      q_head_tag;
  logic [31:0]      q_head_time;

  logic [LW-1:0]    q_limit;
  logic             q_full;
  logic [SCW-1:0]   slots_used;
  logic             in_use;
  logic             last_idx;
  logic             rem_done;
  logic [15:0]      rem_dec;
  logic [31:0]      wait_calc;
  logic [15:0]      svc_ticks;
  logic             in_xfer;
  logic             rd_last;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      service_ticks_q <= 16'd1;
      queue_limit_q   <= 5'd16;
      slot_count_q    <= 4'd8;
    end else if (cfg_we_i) begin
      case (msrs_pkg::cfg_e'(cfg_addr_i))
        msrs_pkg::CFG_SERVICE_TICKS: service_ticks_q <= cfg_wdata_i;
        msrs_pkg::CFG_QUEUE_LIMIT:   queue_limit_q   <= cfg_wdata_i[4:0];
        msrs_pkg::CFG_SLOT_COUNT:    slot_count_q    <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  msrs_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (q_clear),
    .push_i     (q_push),
    .push_tag_i (s_axis_tdata_i),
    .push_time_i(time_q),
    .pop_i      (q_pop),
    .count_o    (q_count),
    .head_tag_o (q_head_tag),
    .head_time_o(q_head_time)
  );

  msrs_rbuf #(
    .DEPTH(RD)
  ) u_rbuf (
    .clk_i  (clk_i),
    .we_i   (rb_we),
    .waddr_i(wr_q[RW-1:0]),
    .wdata_i(rb_wdata),
    .raddr_i(rd_d),
    .rdata_o(rb_rdata)
  );

  // Shared slot unit and limits.
  always_comb begin
    if (LW'(queue_limit_q) > LW'(QUEUE_DEPTH)) begin
      q_limit = LW'(QUEUE_DEPTH);
    end else begin
      q_limit = LW'(queue_limit_q);
    end
    q_full = LW'(q_count) >= q_limit;
    if (SCW'(slot_count_q) > SCW'(MAX_SLOTS)) begin
      slots_used = SCW'(MAX_SLOTS);
    end else begin
      slots_used = SCW'(slot_count_q);
    end
    in_use    = SCW'(idx_q) < slots_used;
    last_idx  = idx_q == SIW'(MAX_SLOTS - 1);
    rem_done  = slot_rem_q[idx_q] <= 16'd1;
    rem_dec   = slot_rem_q[idx_q] - 16'd1;
    wait_calc = time_q - q_head_time;
    svc_ticks = (service_ticks_q == 16'd0) ? 16'd1 : service_ticks_q;
    in_xfer   = s_axis_tvalid_i && (state_q == msrs_pkg::ST_IDLE);
    rd_last   = (NW'(rd_q) + NW'(1)) == wr_q;
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    time_d      = time_q;
    completed_d = completed_q;
    dropped_d   = dropped_q;
    busy_cnt_d  = busy_cnt_q;
    slot_busy_d = slot_busy_q;
    slot_tag_d  = slot_tag_q;
    slot_rem_d  = slot_rem_q;
    wr_d        = wr_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    out_busy_d  = out_busy_q;
    out_depth_d = out_depth_q;
    out_comp_d  = out_comp_q;
    out_drop_d  = out_drop_q;
    out_last_d  = out_last_q;
    rb_we       = 1'b0;
    rb_wdata    = '0;
    q_clear     = 1'b0;
    q_push      = 1'b0;
    q_pop       = 1'b0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      msrs_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (msrs_pkg::op_e'(s_axis_tuser_i))
            msrs_pkg::OP_ARRIVE: begin
              rb_we        = 1'b1;
              rb_wdata.tag = s_axis_tdata_i;
              if (q_full) begin
                rb_wdata.kind = msrs_pkg::KIND_DROPPED;
                if (dropped_q != '1) begin
                  dropped_d = dropped_q + 32'd1;
                end
              end else begin
                rb_wdata.kind = msrs_pkg::KIND_ACCEPTED;
                q_push        = 1'b1;
              end
              wr_d    = wr_q + NW'(1);
              state_d = msrs_pkg::ST_PRIME;
            end
            msrs_pkg::OP_TICK: begin
              time_d  = time_q + 32'd1;
              idx_d   = '0;
              state_d = msrs_pkg::ST_DRAIN;
            end
            msrs_pkg::OP_CLEAR: begin
              q_clear       = 1'b1;
              slot_busy_d   = '0;
              busy_cnt_d    = '0;
              completed_d   = '0;
              dropped_d     = '0;
              rb_we         = 1'b1;
              rb_wdata.kind = msrs_pkg::KIND_STATUS;
              wr_d          = wr_q + NW'(1);
              state_d       = msrs_pkg::ST_PRIME;
            end
            default: ;
          endcase
        end
      end
      msrs_pkg::ST_DRAIN: begin
        if (slot_busy_q[idx_q]) begin
          if (rem_done) begin
            slot_busy_d[idx_q] = 1'b0;
            busy_cnt_d         = busy_cnt_q - UW'(1);
            if (completed_q != '1) begin
              completed_d = completed_q + 32'd1;
            end
            rb_we         = 1'b1;
            rb_wdata.kind = msrs_pkg::KIND_COMPLETED;
            rb_wdata.tag  = slot_tag_q[idx_q];
            wr_d          = wr_q + NW'(1);
          end else begin
            slot_rem_d[idx_q] = rem_dec;
          end
        end
        if (last_idx) begin
          idx_d   = '0;
          state_d = msrs_pkg::ST_FILL;
        end else begin
          idx_d = idx_q + SIW'(1);
        end
      end
      msrs_pkg::ST_FILL: begin
        if (in_use && !slot_busy_q[idx_q] && (q_count != '0)) begin
          q_pop               = 1'b1;
          slot_busy_d[idx_q]  = 1'b1;
          slot_tag_d[idx_q]   = q_head_tag;
          slot_rem_d[idx_q]   = svc_ticks;
          busy_cnt_d          = busy_cnt_q + UW'(1);
          rb_we               = 1'b1;
          rb_wdata.kind       = msrs_pkg::KIND_STARTED;
          rb_wdata.tag        = q_head_tag;
          rb_wdata.wait_ticks = wait_calc;
          wr_d                = wr_q + NW'(1);
        end
        if (last_idx) begin
          state_d = msrs_pkg::ST_STATUS;
        end else begin
          idx_d = idx_q + SIW'(1);
        end
      end
      msrs_pkg::ST_STATUS: begin
        rb_we         = 1'b1;
        rb_wdata.kind = msrs_pkg::KIND_STATUS;
        wr_d          = wr_q + NW'(1);
        state_d       = msrs_pkg::ST_PRIME;
      end
      msrs_pkg::ST_PRIME: begin
        state_d = msrs_pkg::ST_EMIT;
      end
      msrs_pkg::ST_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_res_d   = rb_rdata;
          out_busy_d  = 4'(busy_cnt_q);
          out_depth_d = 5'(q_count);
          out_comp_d  = completed_q;
          out_drop_d  = dropped_q;
          out_last_d  = rd_last;
          if (rd_last) begin
            rd_d    = '0;
            wr_d    = '0;
            state_d = msrs_pkg::ST_IDLE;
          end else begin
            rd_d = rd_q + RW'(1);
          end
        end
      end
      default: begin
        state_d = msrs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msrs_pkg::ST_IDLE;
      idx_q       <= '0;
      time_q      <= '0;
      completed_q <= '0;
      dropped_q   <= '0;
      busy_cnt_q  <= '0;
      slot_busy_q <= '0;
      wr_q        <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      time_q      <= time_d;
      completed_q <= completed_d;
      dropped_q   <= dropped_d;
      busy_cnt_q  <= busy_cnt_d;
      slot_busy_q <= slot_busy_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_tag_q  <= slot_tag_d;
    slot_rem_q  <= slot_rem_d;
    out_res_q   <= out_res_d;
    out_busy_q  <= out_busy_d;
    out_depth_q <= out_depth_d;
    out_comp_q  <= out_comp_d;
    out_drop_q  <= out_drop_d;
    out_last_q  <= out_last_d;
  end

  assign s_axis_tready_o = state_q == msrs_pkg::ST_IDLE;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.kind;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {7'd0, out_drop_q, out_comp_q, out_depth_q, out_busy_q,
                            out_res_q.wait_ticks, out_res_q.tag};

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// Request server testbench
// Drives arrive, tick, clear and unused operations into the multi-slot request
// server on its input stream and compares every output transfer with a
// cycle-free model of the queue, the slots and the counters. A short directed
// table covers reset state, extreme tags and settings; random phases with
// fresh settings, random idling on both sides, a long output hold-off and a
// drain pause follow.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned Q_DEPTH       = 16;
  localparam int unsigned N_SLOTS       = 8;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned IDLE_LIMIT    = 3000;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned RANDOM_ITEMS  = 300;
  localparam int unsigned MAX_GAP       = 18;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  typedef struct packed {
    msrs_pkg::kind_e kind;
    logic [15:0]     tag;
    logic [31:0]     wait_ticks;
    logic [3:0]      busy;
    logic [4:0]      depth;
    logic [31:0]     completed;
    logic [31:0]     dropped;
    logic            is_last;
  } server_result_t;

  typedef struct {
    bit              settings;
    logic [1:0]      op;
    logic [15:0]     value;
    logic [4:0]      limit;
    logic [3:0]      slots;
    bit              typed;
    msrs_pkg::kind_e kind;
    logic [3:0]      busy;
    logic [4:0]      depth;
    logic [31:0]     dropped;
  } stim_row_t;

  logic         clk_i           = 1'b0;
  logic         rst_ni          = 1'b0;
  logic         cfg_we_i        = 1'b0;
  logic [1:0]   cfg_addr_i      = msrs_pkg::CFG_SERVICE_TICKS;
  logic [15:0]  cfg_wdata_i     = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [15:0]  s_axis_tdata_i  = '0;
  logic [1:0]   s_axis_tuser_i  = msrs_pkg::OP_ARRIVE;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [127:0] m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;
  logic         m_axis_tlast_o;

  // Model state of the server.
  logic [15:0] srv_service;
  logic [4:0]  srv_limit;
  logic [3:0]  srv_slots;
  logic [15:0] fifo_tag   [Q_DEPTH];
  logic [31:0] fifo_stamp [Q_DEPTH];
  logic [3:0]  fifo_head;
  logic [4:0]  fifo_count;
  logic        slot_busy  [N_SLOTS];
  logic [15:0] slot_tag   [N_SLOTS];
  logic [15:0] slot_left  [N_SLOTS];
  logic [31:0] clock_now;
  logic [31:0] done_count;
  logic [31:0] drop_count;

  server_result_t due_results[$];
  int unsigned    mismatch_count = 0;
  int unsigned    idle_cycles    = 0;
  bit             tx_fast        = 1'b0;
  bit             hold_pending   = 1'b0;

  always #2 clk_i = ~clk_i;

  multi_slot_request_server_core #(
    .QUEUE_DEPTH(Q_DEPTH),
    .MAX_SLOTS  (N_SLOTS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  function automatic server_result_t make_result(msrs_pkg::kind_e k, logic [15:0] t,
                                                 logic [31:0] w);
    server_result_t r;
    r            = '0;
    r.kind       = k;
    r.tag        = t;
    r.wait_ticks = w;
    return r;
  endfunction

  function automatic stim_row_t plain_row(logic [1:0] op, logic [15:0] tag);
    stim_row_t row;
    row.settings = 1'b0;
    row.op       = op;
    row.value    = tag;
    row.limit    = '0;
    row.slots    = '0;
    row.typed    = 1'b0;
    row.kind     = msrs_pkg::KIND_STATUS;
    row.busy     = '0;
    row.depth    = '0;
    row.dropped  = '0;
    return row;
  endfunction

  function automatic stim_row_t checked_row(logic [1:0] op, logic [15:0] tag,
                                            msrs_pkg::kind_e k,
                                            logic [3:0] busy, logic [4:0] depth,
                                            logic [31:0] dropped);
    stim_row_t row;
    row         = plain_row(op, tag);
    row.typed   = 1'b1;
    row.kind    = k;
    row.busy    = busy;
    row.depth   = depth;
    row.dropped = dropped;
    return row;
  endfunction

  function automatic stim_row_t settings_row(logic [15:0] service, logic [4:0] limit,
                                             logic [3:0] slots);
    stim_row_t row;
    row          = plain_row(msrs_pkg::OP_ARRIVE, service);
    row.settings = 1'b1;
    row.limit    = limit;
    row.slots    = slots;
    return row;
  endfunction

  // Advances the server model by one item; queues its results when record is set.
  task automatic serve_item(input logic [1:0] op, input logic [15:0] req_tag,
                            input bit record);
    server_result_t step[$];
    logic [4:0]     cap;
    logic [3:0]     pos;
    logic [3:0]     busy_n;
    int unsigned    use_n;
    case (op)
      msrs_pkg::OP_ARRIVE: begin
        cap = (srv_limit > Q_DEPTH) ? 5'(Q_DEPTH) : srv_limit;
        if (fifo_count >= cap) begin
          if (drop_count != '1) drop_count++;
          step = {step, make_result(msrs_pkg::KIND_DROPPED, req_tag, '0)};
        end else begin
          pos             = fifo_head + fifo_count[3:0];
          fifo_tag[pos]   = req_tag;
          fifo_stamp[pos] = clock_now;
          fifo_count++;
          step = {step, make_result(msrs_pkg::KIND_ACCEPTED, req_tag, '0)};
        end
      end
      msrs_pkg::OP_TICK: begin
        clock_now++;
        for (int i = 0; i < N_SLOTS; i++) begin
          if (slot_busy[i]) begin
            if (slot_left[i] <= 16'd1) begin
              slot_busy[i] = 1'b0;
              slot_left[i] = '0;
              if (done_count != '1) done_count++;
              step = {step, make_result(msrs_pkg::KIND_COMPLETED, slot_tag[i], '0)};
            end else begin
              slot_left[i]--;
            end
          end
        end
        use_n = (srv_slots > N_SLOTS) ? N_SLOTS : srv_slots;
        for (int i = 0; i < use_n; i++) begin
          if (!slot_busy[i] && fifo_count != 0) begin
            slot_busy[i] = 1'b1;
            slot_tag[i]  = fifo_tag[fifo_head];
            slot_left[i] = srv_service;
            step = {step, make_result(msrs_pkg::KIND_STARTED, fifo_tag[fifo_head],
                                      clock_now - fifo_stamp[fifo_head])};
            fifo_head++;
            fifo_count--;
          end
        end
        step = {step, make_result(msrs_pkg::KIND_STATUS, '0, '0)};
      end
      msrs_pkg::OP_CLEAR: begin
        fifo_head  = '0;
        fifo_count = '0;
        done_count = '0;
        drop_count = '0;
        for (int i = 0; i < N_SLOTS; i++) begin
          slot_busy[i] = 1'b0;
          slot_left[i] = '0;
        end
        step = {step, make_result(msrs_pkg::KIND_STATUS, '0, '0)};
      end
      default: begin
      end
    endcase
    busy_n = '0;
    for (int i = 0; i < N_SLOTS; i++) begin
      if (slot_busy[i]) busy_n++;
    end
    foreach (step[k]) begin
      step[k].busy      = busy_n;
      step[k].depth     = fifo_count;
      step[k].completed = done_count;
      step[k].dropped   = drop_count;
      step[k].is_last   = (k == step.size() - 1);
      if (record) due_results = {due_results, step[k]};
    end
  endtask

  task automatic offer(input stim_row_t row);
    int unsigned    gap;
    server_result_t typed_res;
    gap = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= row.op;
    s_axis_tdata_i  <= row.value;
    do @(posedge clk_i); while (!s_axis_tready_o);
    serve_item(row.op, row.value, !row.typed);
    if (row.typed) begin
      typed_res         = make_result(row.kind, row.value, '0);
      typed_res.busy    = row.busy;
      typed_res.depth   = row.depth;
      typed_res.dropped = row.dropped;
      typed_res.is_last = 1'b1;
      due_results       = {due_results, typed_res};
    end
  endtask

  // Registers change only once the server has gone quiet.
  task automatic apply_settings(input logic [15:0] service, input logic [4:0] limit,
                                input logic [3:0] slots);
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= msrs_pkg::CFG_SERVICE_TICKS;
    cfg_wdata_i <= service;
    @(posedge clk_i);
    cfg_addr_i  <= msrs_pkg::CFG_QUEUE_LIMIT;
    cfg_wdata_i <= {11'b0, limit};
    @(posedge clk_i);
    cfg_addr_i  <= msrs_pkg::CFG_SLOT_COUNT;
    cfg_wdata_i <= {12'b0, slots};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    srv_service = service;
    srv_limit   = limit;
    srv_slots   = slots;
  endtask

  initial begin : stimulus
    stim_row_t   plan[$];
    stim_row_t   row;
    logic [15:0] service;
    logic [4:0]  limit;
    logic [3:0]  slots;
    logic [1:0]  op;
    int unsigned phase;
    int unsigned random_items;
    int unsigned arrive_pct;
    int unsigned pick;
    int unsigned len;
    srv_service = 16'd1;
    srv_limit   = 5'd16;
    srv_slots   = 4'd8;
    fifo_head   = '0;
    fifo_count  = '0;
    clock_now   = '0;
    done_count  = '0;
    drop_count  = '0;
    for (int i = 0; i < N_SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_tag[i]  = '0;
      slot_left[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    plan = {plan, checked_row(msrs_pkg::OP_ARRIVE, 16'h0000, msrs_pkg::KIND_ACCEPTED,
                              4'd0, 5'd1, 32'd0)};
    plan = {plan, checked_row(msrs_pkg::OP_ARRIVE, 16'hFFFF, msrs_pkg::KIND_ACCEPTED,
                              4'd0, 5'd2, 32'd0)};
    plan = {plan, plain_row(OP_UNUSED, 16'h5A5A)};
    plan = {plan, plain_row(msrs_pkg::OP_TICK, 16'h0000)};
    plan = {plan, plain_row(msrs_pkg::OP_TICK, 16'hFFFF)};
    plan = {plan, checked_row(msrs_pkg::OP_CLEAR, 16'h0000, msrs_pkg::KIND_STATUS,
                              4'd0, 5'd0, 32'd0)};
    plan = {plan, settings_row(16'd0, 5'd0, 4'd0)};
    plan = {plan, checked_row(msrs_pkg::OP_ARRIVE, 16'hAAAA, msrs_pkg::KIND_DROPPED,
                              4'd0, 5'd0, 32'd1)};
    plan = {plan, checked_row(msrs_pkg::OP_TICK, 16'h0000, msrs_pkg::KIND_STATUS,
                              4'd0, 5'd0, 32'd1)};
    plan = {plan, settings_row(16'd2, 5'd31, 4'd15)};
    plan = {plan, plain_row(msrs_pkg::OP_ARRIVE, 16'h8001)};
    plan = {plan, plain_row(msrs_pkg::OP_ARRIVE, 16'h7FFE)};
    plan = {plan, plain_row(msrs_pkg::OP_ARRIVE, 16'h0F0F)};
    plan = {plan, plain_row(msrs_pkg::OP_ARRIVE, 16'h1234)};
    plan = {plan, plain_row(msrs_pkg::OP_TICK, 16'h0000)};
    plan = {plan, plain_row(msrs_pkg::OP_TICK, 16'h0000)};
    plan = {plan, settings_row(16'd2, 5'd16, 4'd1)};
    plan = {plan, plain_row(msrs_pkg::OP_ARRIVE, 16'h5555)};
    plan = {plan, plain_row(msrs_pkg::OP_TICK, 16'h0000)};
    plan = {plan, plain_row(msrs_pkg::OP_TICK, 16'h0000)};
    plan = {plan, plain_row(msrs_pkg::OP_TICK, 16'h0000)};
    plan = {plan, settings_row(16'hFFFF, 5'd1, 4'd8)};
    plan = {plan, plain_row(msrs_pkg::OP_ARRIVE, 16'h3C3C)};
    plan = {plan, plain_row(msrs_pkg::OP_ARRIVE, 16'hC3C3)};
    plan = {plan, plain_row(msrs_pkg::OP_TICK, 16'h0000)};
    plan = {plan, plain_row(msrs_pkg::OP_CLEAR, 16'h0000)};

    foreach (plan[i]) begin
      if (plan[i].settings) begin
        apply_settings(plan[i].value, plan[i].limit, plan[i].slots);
      end else begin
        offer(plan[i]);
      end
    end

    phase        = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (phase == 1) begin
        service    = 16'd3;
        limit      = 5'd31;
        slots      = 4'd15;
        arrive_pct = 85;
      end else begin
        case ($urandom_range(0, 7))
          0:       service = 16'd0;
          1:       service = 16'd1;
          2:       service = 16'hFFFF;
          default: service = 16'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 5))
          0:       limit = 5'd0;
          1:       limit = 5'd16;
          2:       limit = 5'($urandom_range(17, 31));
          default: limit = 5'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 5))
          0:       slots = 4'd0;
          1:       slots = 4'($urandom_range(9, 15));
          2:       slots = 4'd8;
          default: slots = 4'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 2))
          0:       arrive_pct = 35;
          1:       arrive_pct = 55;
          default: arrive_pct = 85;
        endcase
      end
      apply_settings(service, limit, slots);
      tx_fast = ($urandom_range(0, 3) == 0);
      if (phase == 2) hold_pending = 1'b1;
      len = $urandom_range(15, 45);
      for (int k = 0; k < len; k++) begin
        if (phase == 4 && k == len / 2) begin
          s_axis_tvalid_i <= 1'b0;
          do @(posedge clk_i); while (due_results.size() != 0);
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          op = msrs_pkg::OP_CLEAR;
        end else if (pick < 6) begin
          op = OP_UNUSED;
        end else if (pick < arrive_pct) begin
          op = msrs_pkg::OP_ARRIVE;
        end else begin
          op = msrs_pkg::OP_TICK;
        end
        row = plain_row(op, 16'($urandom_range(0, 65535)));
        offer(row);
        if (op != OP_UNUSED) random_items++;
      end
      phase++;
    end

    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned    stall;
    bit             rx_fast;
    server_result_t got;
    server_result_t want;
    rx_fast = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall        = LONG_HOLD;
      end else begin
        if ($urandom_range(0, 31) == 0) rx_fast = !rx_fast;
        stall = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got.kind       = msrs_pkg::kind_e'(m_axis_tuser_o);
      got.tag        = m_axis_tdata_o[15:0];
      got.wait_ticks = m_axis_tdata_o[47:16];
      got.busy       = m_axis_tdata_o[51:48];
      got.depth      = m_axis_tdata_o[56:52];
      got.completed  = m_axis_tdata_o[88:57];
      got.dropped    = m_axis_tdata_o[120:89];
      got.is_last    = m_axis_tlast_o;
      if (due_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("Unexpected result transfer: %p", got);
        end
      end else begin
        want = due_results.pop_front();
        if (got != want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("Result mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
